// File: hdl/ucabc_pkg.sv
`timescale 1ns / 1ps
package ucabc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int IN_W          = 32;
   localparam int CFG_W         = 24;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int PHASE_W       = 32;
   localparam int ANGLE_W       = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA_RATE   = 2'd1;

   // floor(2^64 / (2*pi)), split into 32-bit halves for the partial products
   localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
   localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;

   localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h40000000;
   localparam logic [30:0]        ONE_Q30      = 31'h40000000;

   // pipeline depths of the phase reduction and sine units
   localparam int PHASE_LAT    = 4;
   localparam int HORNER_CELLS = 5;
   localparam int SIN_LAT      = HORNER_CELLS + 3;

   // Horner accumulator width
   localparam int SIN_PW = 34;

   // odd polynomial for sin(pi/2 * x) in Q30, highest order first
   localparam logic signed [SIN_PW-1:0] SIN_COEF [0:HORNER_CELLS] = '{
      -34'sd3864,
      34'sd172272,
      -34'sd5026995,
      34'sd85569306,
      -34'sd693598668,
      34'sd1686629713
   };

   // what travels down the Horner chain beside the accumulator
   typedef struct packed {
      logic [30:0] x;
      logic [30:0] x2;
      logic [1:0]  quad;
   } sin_tap_type;

endpackage

// File: hdl/ucabc_phase.sv
`timescale 1ns / 1ps
module ucabc_phase
   import ucabc_pkg::*;
#(
   parameter int SHIFT = 64
) (
   input  logic                      clock,
   input  logic signed [ANGLE_W-1:0] value_in,
   output logic [PHASE_W-1:0]        phase_out
);

   logic [ANGLE_W-1:0] mag_in;
   logic [ANGLE_W-1:0] mag_ff;
   logic [2:0]         neg_ff;
   logic [63:0]        ll_ff, lh_ff, hl_ff, hh_ff;
   logic [63:0]        ll_d_ff, hh_d_ff;
   logic [64:0]        mid_ff;
   logic [127:0]       full_in;
   logic [PHASE_W-1:0] sel_in;
   logic [PHASE_W-1:0] phase_ff;

   assign mag_in = value_in[ANGLE_W-1] ? (~value_in + 64'd1) : value_in;

   // |v| * K over four 32x32 partial products; outer terms wait for the middle sum
   assign full_in = {hh_d_ff, 64'd0} + {31'd0, mid_ff, 32'd0} + {64'd0, ll_d_ff};
   assign sel_in  = full_in[SHIFT+PHASE_W-1:SHIFT];

   always_ff @(posedge clock) begin
      neg_ff   <= {neg_ff[1:0], value_in[ANGLE_W-1]};
      mag_ff   <= mag_in;
      ll_ff    <= mag_ff[31:0]  * INV_TWO_PI_LO;
      lh_ff    <= mag_ff[31:0]  * INV_TWO_PI_HI;
      hl_ff    <= mag_ff[63:32] * INV_TWO_PI_LO;
      hh_ff    <= mag_ff[63:32] * INV_TWO_PI_HI;
      mid_ff   <= {1'b0, lh_ff} + {1'b0, hl_ff};
      ll_d_ff  <= ll_ff;
      hh_d_ff  <= hh_ff;
      phase_ff <= neg_ff[2] ? (~sel_in + 32'd1) : sel_in;
   end

   assign phase_out = phase_ff;

endmodule

// File: hdl/ucabc_horner_cell.sv
`timescale 1ns / 1ps
module ucabc_horner_cell
   import ucabc_pkg::*;
#(
   parameter logic signed [SIN_PW-1:0] COEF = '0
) (
   input  logic                     clock,
   input  logic signed [SIN_PW-1:0] acc_in,
   input  sin_tap_type              tap_in,
   output logic signed [SIN_PW-1:0] acc_out,
   output sin_tap_type              tap_out
);

   logic [SIN_PW-1:0]        mag;
   logic [SIN_PW+30:0]       prod;
   logic [SIN_PW-1:0]        term;
   logic signed [SIN_PW-1:0] acc_in_next;
   logic signed [SIN_PW-1:0] acc_ff;
   sin_tap_type              tap_ff;

   // x2 is never negative, so the sign of the product is that of acc
   assign mag         = acc_in[SIN_PW-1] ? (~acc_in + 1'b1) : acc_in;
   assign prod        = mag * tap_in.x2;
   assign term        = prod[SIN_PW+29:30];
   assign acc_in_next = COEF + (acc_in[SIN_PW-1] ? $signed(~term + 1'b1) : $signed(term));

   always_ff @(posedge clock) begin
      acc_ff <= acc_in_next;
      tap_ff <= tap_in;
   end

   assign acc_out = acc_ff;
   assign tap_out = tap_ff;

endmodule

// File: hdl/ucabc_sin.sv
`timescale 1ns / 1ps
module ucabc_sin
   import ucabc_pkg::*;
(
   input  logic               clock,
   input  logic [PHASE_W-1:0] phase_in,
   output logic signed [31:0] sin_out
);

   logic [30:0]              x_in;
   logic [30:0]              x_ff;
   logic [1:0]               q1_ff;
   logic [61:0]              sq;
   sin_tap_type              tap0_ff;
   sin_tap_type              taps [0:HORNER_CELLS];
   logic signed [SIN_PW-1:0] accs [0:HORNER_CELLS];
   logic [SIN_PW-1:0]        mag;
   logic [SIN_PW+30:0]       prod;
   logic [SIN_PW:0]          y_mag;
   logic [30:0]              y_clip;
   logic signed [31:0]       y_in;
   logic signed [31:0]       y_ff;

   // mirror the quarter position in odd quadrants
   assign x_in = phase_in[30] ? (ONE_Q30 - {1'b0, phase_in[29:0]}) : {1'b0, phase_in[29:0]};
   assign sq   = x_ff * x_ff;

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      q1_ff        <= phase_in[31:30];
      tap0_ff.x    <= x_ff;
      tap0_ff.x2   <= sq[60:30];
      tap0_ff.quad <= q1_ff;
   end

   assign taps[0] = tap0_ff;
   assign accs[0] = SIN_COEF[0];

   for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_cell
      ucabc_horner_cell #(
         .COEF (SIN_COEF[i+1])
      ) u_cell (
         .clock   (clock),
         .acc_in  (accs[i]),
         .tap_in  (taps[i]),
         .acc_out (accs[i+1]),
         .tap_out (taps[i+1])
      );
   end

   // y = p * x, clamped to [0, 1] and signed by the half wave
   assign mag  = accs[HORNER_CELLS][SIN_PW-1] ? (~accs[HORNER_CELLS] + 1'b1)
                                              : accs[HORNER_CELLS];
   assign prod = mag * taps[HORNER_CELLS].x;
   assign y_mag = prod[SIN_PW+30:30];

   always_comb begin
      priority if (accs[HORNER_CELLS][SIN_PW-1] && y_mag != '0) begin
         y_clip = '0;
      end else if (y_mag > {{(SIN_PW-30){1'b0}}, ONE_Q30}) begin
         y_clip = ONE_Q30;
      end else begin
         y_clip = y_mag[30:0];
      end
      y_in = taps[HORNER_CELLS].quad[1] ? -$signed({1'b0, y_clip}) : $signed({1'b0, y_clip});
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign sin_out = y_ff;

endmodule

// File: hdl/unsteady_abc_flow_velocity_core.sv
`timescale 1ns / 1ps
// From start to rsp_valid a request passes two phase reductions and two sine units in a row.
// Throughput: one transaction per cycle; busy stays low, the pipeline is fully fed.
// The rate is set by the row of Horner cells and phase reduction stages, all pipelined.
// Reset (synchronous, active high) clears the valid pipeline and loads both gains with 1.0.
// The receiver cannot stall; each result is shown for one cycle with rsp_valid.
module unsteady_abc_flow_velocity_core
   import ucabc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input transactions
   input  logic                        start,
   output logic                        busy,
   input  logic signed [IN_W-1:0]      req_time_value,
   input  logic signed [IN_W-1:0]      req_pos_x,
   input  logic signed [IN_W-1:0]      req_pos_y,
   input  logic signed [IN_W-1:0]      req_pos_z,
   // results
   output logic                        rsp_valid,
   output logic signed [FRAC_BITS+2:0] rsp_vel_x,
   output logic signed [FRAC_BITS+2:0] rsp_vel_y,
   output logic signed [FRAC_BITS+2:0] rsp_vel_z,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int OUT_W    = FRAC_BITS + 3;
   localparam int LAT      = 5 + 2 * PHASE_LAT + 2 * SIN_LAT;
   localparam int POS_DLY  = 3 + PHASE_LAT + SIN_LAT;
   // t*Omega has 2F fraction bits, each angle F+30; 32 more come from K
   localparam int T_SHIFT  = 32 + 2 * FRAC_BITS;
   localparam int A_SHIFT  = 62 + FRAC_BITS;
   localparam int RND_SH   = 30 - FRAC_BITS;
   localparam logic [33:0] RND_HALF = (FRAC_BITS < 30) ? 34'(64'd1 << (29 - FRAC_BITS)) : 34'd0;
   localparam logic signed [34:0] LIM = 35'(64'd2 << FRAC_BITS);
   localparam logic [CFG_W-1:0] ONE_CFG = CFG_W'(64'd1 << FRAC_BITS);

   // configuration registers
   logic signed [CFG_W-1:0] eps_ff, om_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= ONE_CFG;
         om_ff  <= ONE_CFG;
      end else if (csr_valid) begin
         // writes to unused indexes fall through
         if (csr_index == CSR_EPSILON_GAIN) begin
            eps_ff <= csr_wdata[CFG_W-1:0];
         end
         if (csr_index == CSR_OMEGA_RATE) begin
            om_ff <= csr_wdata[CFG_W-1:0];
         end
      end
   end

   // valid marks ride alongside the datapath
   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // time path: t*Omega -> phase -> sin
   logic signed [IN_W-1:0] t_ff;
   logic signed [55:0]     tom_ff;
   logic [PHASE_W-1:0]     t_phase;
   logic signed [31:0]     t_sin;
   logic signed [55:0]     pe_ff;

   always_ff @(posedge clock) begin
      t_ff   <= req_time_value;
      tom_ff <= t_ff * om_ff;
      pe_ff  <= eps_ff * t_sin;
   end

   ucabc_phase #(
      .SHIFT (T_SHIFT)
   ) u_t_phase (
      .clock     (clock),
      .value_in  ({{8{tom_ff[55]}}, tom_ff}),
      .phase_out (t_phase)
   );

   ucabc_sin u_t_sin (
      .clock    (clock),
      .phase_in (t_phase),
      .sin_out  (t_sin)
   );

   // positions wait for the phase offset p
   logic signed [IN_W-1:0]    pos_dly_ff [0:POS_DLY-1][0:2];
   logic signed [ANGLE_W-1:0] angle_ff   [0:2];

   always_ff @(posedge clock) begin
      pos_dly_ff[0][0] <= req_pos_x;
      pos_dly_ff[0][1] <= req_pos_y;
      pos_dly_ff[0][2] <= req_pos_z;
      for (int k = 1; k < POS_DLY; k++) begin
         pos_dly_ff[k] <= pos_dly_ff[k-1];
      end
   end

   logic [PHASE_W-1:0] a_phase [0:2];
   logic signed [31:0] a_sin   [0:2];
   logic signed [31:0] a_cos   [0:2];

   for (genvar i = 0; i < 3; i++) begin : g_axis
      always_ff @(posedge clock) begin
         // angle = pos * 2^30 + p, F+30 fraction bits
         angle_ff[i] <= {{2{pos_dly_ff[POS_DLY-1][i][IN_W-1]}}, pos_dly_ff[POS_DLY-1][i], 30'd0}
                        + {{8{pe_ff[55]}}, pe_ff};
      end

      ucabc_phase #(
         .SHIFT (A_SHIFT)
      ) u_phase (
         .clock     (clock),
         .value_in  (angle_ff[i]),
         .phase_out (a_phase[i])
      );

      ucabc_sin u_sin (
         .clock    (clock),
         .phase_in (a_phase[i]),
         .sin_out  (a_sin[i])
      );

      // cosine as sine a quarter turn ahead
      ucabc_sin u_cos (
         .clock    (clock),
         .phase_in (a_phase[i] + QUARTER_TURN),
         .sin_out  (a_cos[i])
      );
   end

   // round to F fraction bits (halves up) and saturate to [-2, 2]
   logic signed [32:0]    sum  [0:2];
   logic [33:0]           ubias[0:2];
   logic [33:0]           urnd [0:2];
   logic signed [34:0]    rv   [0:2];
   logic signed [OUT_W-1:0] vel_in [0:2];
   logic signed [OUT_W-1:0] vel_ff [0:2];

   always_comb begin
      // x uses z and y, y uses x and z, z uses y and x
      sum[0] = 33'(a_sin[2]) + 33'(a_cos[1]);
      sum[1] = 33'(a_sin[0]) + 33'(a_cos[2]);
      sum[2] = 33'(a_sin[1]) + 33'(a_cos[0]);
      for (int i = 0; i < 3; i++) begin
         ubias[i] = 34'(sum[i]) + 34'h080000000;
         urnd[i]  = (ubias[i] + RND_HALF) >> RND_SH;
         rv[i]    = $signed({1'b0, urnd[i]}) - LIM;
         priority if (rv[i] > LIM) begin
            vel_in[i] = OUT_W'(LIM);
         end else if (rv[i] < -LIM) begin
            vel_in[i] = OUT_W'(-LIM);
         end else begin
            vel_in[i] = OUT_W'(rv[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      vel_ff <= vel_in;
   end

   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];
   assign rsp_vel_z = vel_ff[2];

endmodule
